// File: src/home_computer_bank_decoder_unit_assert.svh
`ifndef HOME_COMPUTER_BANK_DECODER_UNIT_ASSERT_SVH
`define HOME_COMPUTER_BANK_DECODER_UNIT_ASSERT_SVH

// clocked check, off while in reset
`define HCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define HCBD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/hcbd_pkg.sv
package hcbd_pkg;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_VIDEO = 2'd2;

  localparam logic [3:0] TGT_RAM    = 4'd0;
  localparam logic [3:0] TGT_BASIC  = 4'd1;
  localparam logic [3:0] TGT_CHAR   = 4'd2;
  localparam logic [3:0] TGT_KERNAL = 4'd3;
  localparam logic [3:0] TGT_VIDEO  = 4'd4;
  localparam logic [3:0] TGT_TIMER1 = 4'd5;
  localparam logic [3:0] TGT_TIMER2 = 4'd6;
  localparam logic [3:0] TGT_COLOR  = 4'd7;
  localparam logic [3:0] TGT_PORT   = 4'd8;

  localparam int MSK_KERNAL = 0;
  localparam int MSK_CHAR   = 1;
  localparam int MSK_BASIC  = 2;
  localparam int MSK_IO     = 3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  timer2_port_a;
  } item_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] device_address;
    logic        device_write;
    logic        also_ram_write;
    logic [7:0]  data;
    logic        color_fetch;
  } result_t;

  typedef struct packed {
    logic       en;
    logic       sel;
    logic [7:0] data;
  } port_wr_t;

  function automatic logic [3:0] bank_mask_of(input logic [2:0] code);
    logic [3:0] m;
    case (code)
      3'd7: m = 4'hD;
      3'd6: m = 4'h9;
      3'd5: m = 4'h8;
      3'd3: m = 4'h7;
      3'd2: m = 4'h3;
      3'd1: m = 4'h2;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] io_target(input logic [15:0] a, input logic [3:0] mask);
    logic [3:0] t;
    t = TGT_RAM;
    if (mask[MSK_IO]) begin
      if (a[15:10] == 6'b110100) t = TGT_VIDEO;        // D000-D3FF
      else if (a[15:8] == 8'hDC) t = TGT_TIMER1;
      else if (a[15:8] == 8'hDD) t = TGT_TIMER2;
      else if (a[15:10] == 6'b110110) t = TGT_COLOR;   // D800-DBFF
    end
    return t;
  endfunction

endpackage

// File: src/hcbd_decode.sv
module hcbd_decode
  import hcbd_pkg::*;
(
  input  item_t           item,
  input  logic [3:0]      mask,
  input  logic [1:0][7:0] port_bytes,
  output result_t         res,
  output port_wr_t        port_wr
);

  logic       is_port;
  logic [1:0] bank;

  assign is_port = (item.address[15:1] == 15'd0);
  assign bank    = ~item.timer2_port_a[1:0];

  always_comb begin
    res = '0;
    res.device_address = item.address;
    port_wr = '0;
    port_wr.sel  = item.address[0];
    port_wr.data = item.write_data;
    case (item.mode)
      MODE_VIDEO: begin
        res.device_address = {bank, item.address[13:0]};
        res.color_fetch    = 1'b1;
        if (res.device_address[14:12] == 3'b001) res.target = TGT_CHAR;
      end
      MODE_WRITE: begin
        res.device_write = 1'b1;
        res.data         = item.write_data;
        if (is_port) begin
          res.target         = TGT_PORT;
          res.also_ram_write = 1'b1;
          port_wr.en         = 1'b1;
        end else begin
          res.target = io_target(item.address, mask);
        end
      end
      default: begin
        if (is_port) begin
          res.target = TGT_PORT;
          res.data   = port_bytes[item.address[0]];
        end else if (mask[MSK_KERNAL] && item.address[15:13] == 3'b111) begin
          res.target = TGT_KERNAL;
        end else if (mask[MSK_CHAR] && item.address[15:12] == 4'hD) begin
          res.target = TGT_CHAR;
        end else if (mask[MSK_BASIC] && item.address[15:13] == 3'b101) begin
          res.target = TGT_BASIC;
        end else begin
          res.target = io_target(item.address, mask);
        end
      end
    endcase
  end

endmodule

// File: src/home_computer_bank_decoder_unit.sv
// Bus access bank decoder.
// Input register, then result register; decode is one shallow compare/mux level.
// Throughput: one transaction per cycle while the result is not stalled by out_stall.
// Reset (rst_n low, synchronous): port bytes and bank mask cleared (all RAM),
// both pipeline stages emptied.
module home_computer_bank_decoder_unit
  import hcbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_timer2_port_a,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_target,
  output logic [15:0] out_device_address,
  output logic        out_device_write,
  output logic        out_also_ram_write,
  output logic [7:0]  out_out_data,
  output logic        out_color_fetch
);

  logic            s1_valid_r;
  item_t           s1_item_r;
  logic            out_valid_r;
  result_t         res_r;
  logic [1:0][7:0] port_r;
  logic [3:0]      mask_r;

  result_t         res_nxt;
  port_wr_t        port_wr;
  logic [7:0]      port1_nxt;
  logic            advance;
  logic            s1_load;

  hcbd_decode u_decode (
    .item       (s1_item_r),
    .mask       (mask_r),
    .port_bytes (port_r),
    .res        (res_nxt),
    .port_wr    (port_wr)
  );

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign s1_load  = !s1_valid_r || advance;
  assign in_stall = !s1_load;

  assign port1_nxt = (port_wr.sel) ? port_wr.data : port_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      port_r      <= '0;
      mask_r      <= '0;
    end else begin
      if (s1_load) s1_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (advance && port_wr.en) begin
        port_r[port_wr.sel] <= port_wr.data;
        mask_r              <= bank_mask_of(port1_nxt[2:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_item_r <= '{mode: in_mode, address: in_address, write_data: in_write_data,
                     timer2_port_a: in_timer2_port_a};
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_target         = res_r.target;
  assign out_device_address = res_r.device_address;
  assign out_device_write   = res_r.device_write;
  assign out_also_ram_write = res_r.also_ram_write;
  assign out_out_data       = res_r.data;
  assign out_color_fetch    = res_r.color_fetch;

endmodule

// File: src/hcbd_checker.sv
`include "home_computer_bank_decoder_unit_assert.svh"

module hcbd_checker
  import hcbd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_target,
  input logic [15:0] out_device_address,
  input logic        out_device_write,
  input logic        out_also_ram_write,
  input logic [7:0]  out_out_data,
  input logic        out_color_fetch
);

  `HCBD_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `HCBD_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_target) &&
      $stable(out_device_address) && $stable(out_out_data),
    "stalled result changed")
  `HCBD_ASSERT(a_in_stall_src, in_stall |-> out_valid && out_stall,
    "input stalled while result side free")
  `HCBD_ASSERT(a_ram_wr_port,
    out_valid && out_also_ram_write |-> out_target == TGT_PORT && out_device_write,
    "ram shadow write without port write")
  `HCBD_ASSERT(a_fetch_kind,
    out_valid && out_color_fetch |->
      !out_device_write && (out_target == TGT_RAM || out_target == TGT_CHAR),
    "video fetch decoded as cpu access")

endmodule

bind home_computer_bank_decoder_unit hcbd_checker u_hcbd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_target         (out_target),
  .out_device_address (out_device_address),
  .out_device_write   (out_device_write),
  .out_also_ram_write (out_also_ram_write),
  .out_out_data       (out_out_data),
  .out_color_fetch    (out_color_fetch)
);
